// ----- hdl/imh_pkg.sv -----
package imh_pkg;

  localparam int DEF_HEAP_DEPTH   = 1024;
  localparam int DEF_VALUE_BITS   = 64;
  localparam int SLOT_BITS        = 10;
  localparam int HANDLE_BITS      = 10;
  localparam int LEN_BITS         = 11;
  localparam int VALUE_FIELD_BITS = 64;
  localparam int HANDLE_COUNT     = 1024;

  typedef struct packed {
    logic [SLOT_BITS-1:0]        slot;
    logic [VALUE_FIELD_BITS-1:0] key_value;
    logic [HANDLE_BITS-1:0]      handle;
    logic [LEN_BITS-1:0]         heap_length;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]        final_slot;
    logic [VALUE_FIELD_BITS-1:0] top_value;
    logic [HANDLE_BITS-1:0]      top_handle;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINAL,
    ST_TOP_RD,
    ST_TOP
  } state_t;

endpackage

// ----- hdl/imh_heap_ram.sv -----
module imh_heap_ram
  import imh_pkg::*;
#(
  parameter int DEPTH = DEF_HEAP_DEPTH,
  parameter int WIDTH = DEF_VALUE_BITS + HANDLE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/indexed_min_heap_update.sv -----
// sequence: each heap level visited takes a read state and a compare state; the final
//   write, a root read and the result state follow
// throughput: one transaction at a time; busy stays high until the result strobe, set by
//   the read-compare-write loop on the heap memory
// reset: after rst_n the handle position table is cleared, one entry a cycle across the
//   whole table with busy high; results are strobed for one cycle and cannot be stalled
module indexed_min_heap_update
  import imh_pkg::*;
#(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW   = $clog2(HEAP_DEPTH);
  localparam int LENW = $clog2(HEAP_DEPTH + 1);
  localparam int IW   = AW + 2;
  localparam int HW   = VALUE_BITS + HANDLE_BITS;
  localparam logic [HANDLE_BITS-1:0] CLR_LAST = HANDLE_BITS'(HANDLE_COUNT - 1);

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          at_r, at_nxt;
  logic [LENW-1:0]        len_r, len_nxt;
  logic [VALUE_BITS-1:0]  v_r, v_nxt;
  logic [HANDLE_BITS-1:0] h_r, h_nxt;
  logic                   moved_r, moved_nxt;
  logic [HANDLE_BITS-1:0] clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  // heap memory ports
  logic          hp_we, hp_rd;
  logic [AW-1:0] hp_waddr, hp_raddr_a, hp_raddr_b;
  logic [HW-1:0] hp_wdata, hp_rdata_a, hp_rdata_b;

  // handle position table
  logic [SLOT_BITS-1:0]   pos_mem [HANDLE_COUNT];
  logic                   pos_we;
  logic [HANDLE_BITS-1:0] pos_addr;
  logic [SLOT_BITS-1:0]   pos_data;

  // entry decode
  logic [31:0] slot_w, len_w;

  // tree navigation
  logic [AW-1:0]          parent;
  logic [IW-1:0]          l_idx, r_idx, len_ext;
  logic [VALUE_BITS-1:0]  a_val, b_val;
  logic [HANDLE_BITS-1:0] a_hdl, b_hdl;
  logic                   l_ok, r_ok, take_l, take_r, up_move;

  imh_heap_ram #(
    .DEPTH(HEAP_DEPTH),
    .WIDTH(HW)
  ) u_heap_ram (
    .clk    (clk),
    .we     (hp_we),
    .waddr  (hp_waddr),
    .wdata  (hp_wdata),
    .rd_en  (hp_rd),
    .raddr_a(hp_raddr_a),
    .raddr_b(hp_raddr_b),
    .rdata_a(hp_rdata_a),
    .rdata_b(hp_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_addr] <= pos_data;
    end
  end

  // clamp slot and length into the heap and make the length cover the slot
  always_comb begin
    slot_w = 32'(in_item.slot);
    if (slot_w >= 32'(HEAP_DEPTH)) begin
      slot_w = 32'(HEAP_DEPTH - 1);
    end
    len_w = 32'(in_item.heap_length);
    if (len_w > 32'(HEAP_DEPTH)) begin
      len_w = 32'(HEAP_DEPTH);
    end
    if (len_w <= slot_w) begin
      len_w = slot_w + 32'd1;
    end
  end

  assign parent  = AW'((at_r - AW'(1)) >> 1);
  assign l_idx   = IW'({at_r, 1'b1});
  assign r_idx   = IW'({at_r, 1'b0}) + IW'(2);
  assign len_ext = IW'(len_r);
  assign a_val   = hp_rdata_a[HANDLE_BITS +: VALUE_BITS];
  assign a_hdl   = hp_rdata_a[HANDLE_BITS-1:0];
  assign b_val   = hp_rdata_b[HANDLE_BITS +: VALUE_BITS];
  assign b_hdl   = hp_rdata_b[HANDLE_BITS-1:0];

  // strict compares keep equal values from passing each other
  assign l_ok    = l_idx < len_ext;
  assign r_ok    = r_idx < len_ext;
  assign take_l  = l_ok && (a_val < v_r);
  assign take_r  = r_ok && (b_val < v_r) && (!take_l || (b_val < a_val));
  assign up_move = a_val > v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_r       <= at_nxt;
    len_r      <= len_nxt;
    v_r        <= v_nxt;
    h_r        <= h_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    at_nxt        = at_r;
    len_nxt       = len_r;
    v_nxt         = v_r;
    h_nxt         = h_r;
    moved_nxt     = moved_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    hp_we         = 1'b0;
    hp_waddr      = at_r;
    hp_wdata      = {v_r, h_r};
    hp_rd         = 1'b0;
    hp_raddr_a    = parent;
    hp_raddr_b    = AW'(r_idx);
    pos_we        = 1'b0;
    pos_addr      = h_r;
    pos_data      = SLOT_BITS'(at_r);

    unique case (state_r)
      ST_CLEAR: begin
        pos_we   = 1'b1;
        pos_addr = clr_r;
        pos_data = '0;
        clr_nxt  = clr_r + HANDLE_BITS'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          at_nxt    = AW'(slot_w);
          len_nxt   = LENW'(len_w);
          v_nxt     = VALUE_BITS'(in_item.key_value);
          h_nxt     = in_item.handle;
          moved_nxt = 1'b0;
          state_nxt = (slot_w == 32'd0) ? ST_DN_RD : ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        hp_rd      = 1'b1;
        hp_raddr_a = parent;
        state_nxt  = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (up_move) begin
          // parent slides down into the hole
          hp_we     = 1'b1;
          hp_wdata  = hp_rdata_a;
          pos_we    = 1'b1;
          pos_addr  = a_hdl;
          at_nxt    = parent;
          moved_nxt = 1'b1;
          state_nxt = (parent == '0) ? ST_FINAL : ST_UP_RD;
        end else begin
          state_nxt = moved_r ? ST_FINAL : ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        hp_rd      = 1'b1;
        hp_raddr_a = AW'(l_idx);
        hp_raddr_b = AW'(r_idx);
        state_nxt  = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (take_r) begin
          hp_we     = 1'b1;
          hp_wdata  = hp_rdata_b;
          pos_we    = 1'b1;
          pos_addr  = b_hdl;
          at_nxt    = AW'(r_idx);
          state_nxt = ST_DN_RD;
        end else if (take_l) begin
          hp_we     = 1'b1;
          hp_wdata  = hp_rdata_a;
          pos_we    = 1'b1;
          pos_addr  = a_hdl;
          at_nxt    = AW'(l_idx);
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        hp_we     = 1'b1;
        pos_we    = 1'b1;
        state_nxt = ST_TOP_RD;
      end
      ST_TOP_RD: begin
        // root is read after the final write has landed
        hp_rd      = 1'b1;
        hp_raddr_a = '0;
        state_nxt  = ST_TOP;
      end
      ST_TOP: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.final_slot = SLOT_BITS'(at_r);
        out_item_nxt.top_value  = VALUE_FIELD_BITS'(a_val);
        out_item_nxt.top_handle = a_hdl;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_from_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_TOP))
    else $error("result strobe without a finished transaction");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_sink_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DN_CMP && (take_l || take_r)) |=> (at_r > $past(at_r)))
    else $error("sift down did not move to a child");

  a_rise_ascends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP_CMP && up_move) |=> (at_r < $past(at_r)))
    else $error("sift up did not move to the parent");

  a_slot_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_CLEAR) |-> (IW'(at_r) < len_ext))
    else $error("working slot outside the heap length");

endmodule

// ----- tb/tb_indexed_min_heap_update.sv -----
module tb_indexed_min_heap_update;
  import imh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH      = DEF_HEAP_DEPTH;
  localparam logic [63:0] KEY_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          QUIET_MAX  = 4000;
  localparam int          N_DIRECTED = 12;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  indexed_min_heap_update u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // shadow copy of the heap and the handle position table
  logic [63:0] heap_val_m [DEPTH];
  logic [9:0]  heap_hnd_m [DEPTH];
  logic [9:0]  slot_of_handle_m [HANDLE_COUNT];

  out_item_t pending_results [$];
  dir_row_t  directed_rows [N_DIRECTED];
  out_item_t want_now;

  int written_slots = 0;   // slots 0..written_slots-1 hold an entry
  int heap_size     = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_removes     = 0;
  int n_long        = 0;
  bit idle_enable   = 1'b1;

  function automatic void place_entry(int at, logic [63:0] v, logic [9:0] h);
    heap_val_m[at]      = v;
    heap_hnd_m[at]      = h;
    slot_of_handle_m[h] = at[9:0];
  endfunction

  function automatic out_item_t heap_model_update(in_item_t it);
    int          at;
    int          len;
    int          up;
    int          l;
    int          r;
    int          best;
    logic [63:0] v;
    logic [63:0] best_v;
    logic [9:0]  h;
    bit          done;
    out_item_t   res;
    at = int'(it.slot);
    if (at >= DEPTH) at = DEPTH - 1;
    len = int'(it.heap_length);
    if (len > DEPTH) len = DEPTH;
    if (len <= at) len = at + 1;
    v = it.key_value;
    h = it.handle;
    place_entry(at, v, h);
    done = 1'b0;
    if (at > 0 && heap_val_m[(at - 1) / 2] > v) begin
      while (at > 0 && !done) begin
        up = (at - 1) / 2;
        if (!(heap_val_m[up] > v)) begin
          done = 1'b1;
        end else begin
          place_entry(at, heap_val_m[up], heap_hnd_m[up]);
          at = up;
        end
      end
    end else begin
      while (!done) begin
        l = 2 * at + 1;
        r = 2 * at + 2;
        best = at;
        best_v = v;
        if (l < len && heap_val_m[l] < best_v) begin
          best = l;
          best_v = heap_val_m[l];
        end
        if (r < len && heap_val_m[r] < best_v) best = r;
        if (best == at) begin
          done = 1'b1;
        end else begin
          place_entry(at, heap_val_m[best], heap_hnd_m[best]);
          at = best;
        end
      end
    end
    place_entry(at, v, h);
    res.final_slot = at[9:0];
    res.top_value  = heap_val_m[0];
    res.top_handle = heap_hnd_m[0];
    return res;
  endfunction

  function automatic logic [63:0] random_key();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return KEY_MAX;
      2, 3:    return 64'($urandom_range(0, 15));
      4:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // heap operations as a caller would compose them, plus some loose writes
  task automatic build_op(input int grow_pct, input int size_cap, output in_item_t it);
    int r;
    int pick;
    int s;
    int raw;
    int eff;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 3);
    it = '0;
    it.key_value = random_key();
    it.handle = 10'($urandom_range(0, 1023));
    if (heap_size == 0 || (r < grow_pct && heap_size < size_cap)) begin
      it.slot = 10'(heap_size);
      it.heap_length = 11'(heap_size + 1);
      heap_size++;
    end else if (pick <= 1) begin
      s = $urandom_range(0, heap_size - 1);
      it.slot = 10'(s);
      it.handle = heap_hnd_m[s];
      it.heap_length = 11'(heap_size);
    end else if (pick == 2 && heap_size > 1) begin
      s = $urandom_range(0, heap_size - 2);
      it.slot = 10'(s);
      it.key_value = heap_val_m[heap_size - 1];
      it.handle = heap_hnd_m[heap_size - 1];
      it.heap_length = 11'(heap_size - 1);
      heap_size--;
      n_removes++;
    end else begin
      s = $urandom_range(0, (written_slots < DEPTH) ? written_slots : DEPTH - 1);
      raw = $urandom_range(0, 2047);
      eff = (raw > DEPTH) ? DEPTH : raw;
      if (eff <= s) eff = s + 1;
      if ((s < written_slots) ? (eff > written_slots) : (eff > written_slots + 1))
        raw = $urandom_range(0, s);
      it.slot = 10'(s);
      it.heap_length = 11'(raw);
    end
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t got;
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = heap_model_update(it);
    pending_results.push_back(typed ? want : got);
    if (it.slot == written_slots) written_slots++;
    if (it.heap_length > DEPTH) n_long++;
    n_items++;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid) begin
        n_results++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: slot %0d top %h/%0d",
                     out_item.final_slot, out_item.top_value, out_item.top_handle);
        end else begin
          want_now = pending_results.pop_front();
          if (out_item.final_slot !== want_now.final_slot ||
              out_item.top_value !== want_now.top_value ||
              out_item.top_handle !== want_now.top_handle) begin
            error_count++;
            if (error_count <= 10)
              $display("result %0d: expected slot %0d top %h/%0d, got slot %0d top %h/%0d",
                       n_results, want_now.final_slot, want_now.top_value,
                       want_now.top_handle, out_item.final_slot, out_item.top_value,
                       out_item.top_handle);
          end
        end
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("timeout after %0d quiet cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("indexed_min_heap_update: mismatch");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    for (int i = 0; i < HANDLE_COUNT; i++) slot_of_handle_m[i] = '0;

    // slot, key, handle, length, typed, final_slot, top_value, top_handle
    directed_rows[0]  = {10'd0, 64'd50, 10'd5, 11'd1, 1'b1, 10'd0, 64'd50, 10'd5};
    directed_rows[1]  = {10'd1, KEY_MAX, 10'd1023, 11'd2, 1'b1, 10'd1, 64'd50, 10'd5};
    directed_rows[2]  = {10'd2, 64'd0, 10'd0, 11'd3, 1'b1, 10'd0, 64'd0, 10'd0};
    directed_rows[3]  = {10'd3, 64'd50, 10'd3, 11'd4, 1'b0, 84'd0};
    // both children equal: goes left only
    directed_rows[4]  = {10'd0, KEY_MAX, 10'd7, 11'd4, 1'b0, 84'd0};
    // zero length and a length that does not reach the slot
    directed_rows[5]  = {10'd1, 64'd50, 10'd9, 11'd0, 1'b0, 84'd0};
    directed_rows[6]  = {10'd3, 64'd1, 10'd512, 11'd1, 1'b0, 84'd0};
    directed_rows[7]  = {10'd4, 64'd50, 10'd1022, 11'd5, 1'b0, 84'd0};
    directed_rows[8]  = {10'd2, 64'h8000_0000_0000_0000, 10'd341, 11'd5, 1'b0, 84'd0};
    directed_rows[9]  = {10'd4, 64'd0, 10'd682, 11'd5, 1'b0, 84'd0};
    directed_rows[10] = {10'd0, 64'd50, 10'd0, 11'd5, 1'b0, 84'd0};
    directed_rows[11] = {10'd1, 64'h7FFF_FFFF_FFFF_FFFF, 10'd1, 11'd3, 1'b0, 84'd0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    heap_size = written_slots;

    // small heap with inserts, key changes, removes and loose writes
    repeat (60) begin
      build_op(40, 24, it);
      send_item(it, 1'b0, '0);
    end
    drain_results();

    // grow until every slot holds an entry
    while (written_slots < DEPTH) begin
      build_op(95, DEPTH, it);
      send_item(it, 1'b0, '0);
    end
    drain_results();

    // full heap, back to back
    idle_enable = 1'b0;
    send_item({10'd1023, 64'd0, 10'd1023, 11'd2047}, 1'b0, '0);
    send_item({10'd1023, KEY_MAX, 10'd0, 11'd1024}, 1'b0, '0);
    send_item({10'd0, KEY_MAX, 10'd512, 11'd1025}, 1'b0, '0);
    send_item({10'd0, 64'd0, 10'd1, 11'd0}, 1'b0, '0);
    repeat (80) begin
      build_op(30, DEPTH, it);
      send_item(it, 1'b0, '0);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) error_count++;

    $display("%0d transactions, %0d results; heap filled to %0d slots, %0d removes,",
             n_items, n_results, written_slots, n_removes);
    $display("%0d lengths past the depth; %0d mismatches", n_long, error_count);
    if (error_count == 0) begin
      $display("indexed_min_heap_update: match");
    end else begin
      $display("indexed_min_heap_update: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/imh_pkg.sv
hdl/imh_heap_ram.sv
hdl/indexed_min_heap_update.sv
tb/tb_indexed_min_heap_update.sv
